FILE: rtl/lzr_pkg.sv
// Shared types and constants for the LZSS ring decompressor.
`default_nettype none

package lzr_pkg;

	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 12;
	localparam int LEN_W    = 5;
	localparam int COUNT_W  = 25;
	localparam int LIMIT_W  = 24;
	localparam int FS_W     = 17;
	localparam int FLAG_BIT = 8;

	localparam int FIFO_DEPTH = 2;

	localparam logic OP_DATA    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [FS_W-1:0]    FLAG_SHIFT_RESET = 17'h10000;
	localparam logic [FS_W-1:0]    FLAG_MARK        = 17'h00100;
	localparam logic [COUNT_W-1:0] CONSUMED_MAX     = 25'h1FFFFFF;
	localparam logic [LEN_W-1:0]   LEN_BIAS         = 5'd2;

	typedef enum logic [1:0] {
		CMD_LIT   = 2'd0,
		CMD_MATCH = 2'd1,
		CMD_END   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		PH_TOKEN      = 3'b001,
		PH_AFTER_FLAG = 3'b010,
		PH_MATCH2     = 3'b100
	} phase_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [BYTE_W-1:0]     data;
		logic [OFFSET_W-1:0]   offset;
		logic [LEN_W-1:0]      length;
		logic                  fin;
		logic [COUNT_W-1:0]    consumed;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/lzss_ring_decompressor.sv
// Top level of the LZSS decompressor with a 4096-byte history ring.
//
//   Channel  Handshake                Payload
//   -------  -----------------------  ---------------------------------------------
//   cmp      cmp_valid / cmp_stall    operation, in_byte (one compressed request)
//   dec      dec_valid / dec_stall    out_byte, byte_valid, run_last, finished,
//                                     produced_count, consumed_count
//   cfg      cfg_wr_en                output_limit (written on any enabled edge)
//
// The parser takes one compressed request per cycle while the command queue has room.
// The copy engine emits one decompressed byte per cycle unless the output stalls, so a
// match of L bytes (2 to 17) holds it for the whole copy; the ring read is registered.
// Reset and restart clear no memory: a fill pointer makes never-written entries read zero.
// Either side may stall independently; the command queue and output register absorb it.
`default_nettype none

module lzss_ring_decompressor
	import lzr_pkg::*;
#(
	parameter int RING_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] output_limit,
	input  logic               cmp_valid,
	output logic               cmp_stall,
	input  logic               operation,
	input  logic [BYTE_W-1:0]  in_byte,
	output logic               dec_valid,
	input  logic               dec_stall,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               finished,
	output logic [COUNT_W-1:0] produced_count,
	output logic [COUNT_W-1:0] consumed_count
);

	logic cmd_push;
	cmd_t push_cmd;
	logic cmd_pop;
	logic fifo_full;
	logic cmd_avail;
	cmd_t head_cmd;

	// A request is only stalled by a full command queue; every request can then be
	// taken, whether or not it produces a command.
	assign cmp_stall = fifo_full;

	lzr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.output_limit(output_limit),
		.cmp_valid   (cmp_valid),
		.cmp_stall   (cmp_stall),
		.operation   (operation),
		.in_byte     (in_byte),
		.cmd_push    (cmd_push),
		.cmd         (push_cmd)
	);

	lzr_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.push_cmd(push_cmd),
		.pop     (cmd_pop),
		.full    (fifo_full),
		.avail   (cmd_avail),
		.head    (head_cmd)
	);

	lzr_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_avail     (cmd_avail),
		.cmd_in        (head_cmd),
		.cmd_pop       (cmd_pop),
		.dec_valid     (dec_valid),
		.dec_stall     (dec_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.finished      (finished),
		.produced_count(produced_count),
		.consumed_count(consumed_count)
	);

	// Decoding only ends on the last result of a token.
	a_finish_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && finished |-> run_last)
		else $error("finished result is not the last of its request");

	// A result without data is always a lone end-of-stream result.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !byte_valid |-> finished && run_last && (out_byte == '0))
		else $error("result without data is not an end result");

	// The parser never pushes into a full command queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !fifo_full)
		else $error("command pushed into full queue");

endmodule

`default_nettype wire

FILE: rtl/lzr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lzr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lzr_front.sv
// Front end: parses compressed bytes into literal, match, end and clear commands.
`default_nettype none

module lzr_front
	import lzr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] output_limit,
	input  logic               cmp_valid,
	input  logic               cmp_stall,
	input  logic               operation,
	input  logic [BYTE_W-1:0]  in_byte,
	output logic               cmd_push,
	output cmd_t               cmd
);

	logic [LIMIT_W-1:0] limit_q;
	phase_t             phase_q, phase_d;
	logic [FS_W-1:0]    flag_shift_q, flag_shift_d;
	logic [BYTE_W-1:0]  match_high_q, match_high_d;
	logic [COUNT_W-1:0] shadow_q, shadow_d;
	logic [COUNT_W-1:0] consumed_q, consumed_d;
	logic               done_q, done_d;

	logic               accept;
	logic [COUNT_W-1:0] limit_val;
	logic [COUNT_W-1:0] consumed_inc;
	logic [FS_W-1:0]    fs_shifted;
	logic [LEN_W-1:0]   match_len;
	logic [COUNT_W-1:0] shadow_lit;
	logic [COUNT_W-1:0] shadow_match;

	assign accept       = cmp_valid && !cmp_stall;
	// A limit of zero stands for the full 2^24 bytes.
	assign limit_val    = {(limit_q == '0), limit_q};
	assign consumed_inc = (consumed_q == CONSUMED_MAX) ? consumed_q : consumed_q + 1'b1;
	assign fs_shifted   = {flag_shift_q[FS_W-2:0], 1'b0};
	assign match_len    = {1'b0, match_high_q[3:0]} + LEN_BIAS;
	assign shadow_lit   = shadow_q + 1'b1;
	assign shadow_match = shadow_q + COUNT_W'(match_len);

	always_comb begin
		phase_d      = phase_q;
		flag_shift_d = flag_shift_q;
		match_high_d = match_high_q;
		shadow_d     = shadow_q;
		consumed_d   = consumed_q;
		done_d       = done_q;
		cmd_push     = 1'b0;
		cmd.kind     = CMD_LIT;
		cmd.data     = in_byte;
		cmd.offset   = {match_high_q[7:4], in_byte};
		cmd.length   = match_len;
		cmd.fin      = 1'b0;
		cmd.consumed = consumed_inc;
		if (accept) begin
			if (operation == OP_RESTART) begin
				phase_d      = PH_TOKEN;
				flag_shift_d = FLAG_SHIFT_RESET;
				match_high_d = '0;
				shadow_d     = '0;
				consumed_d   = '0;
				done_d       = 1'b0;
				cmd.kind     = CMD_CLEAR;
				cmd_push     = 1'b1;
			end else if (!done_q) begin
				unique case (phase_q) inside
					PH_MATCH2: begin
						consumed_d = consumed_inc;
						shadow_d   = shadow_match;
						cmd.kind   = CMD_MATCH;
						cmd.fin    = (shadow_match >= limit_val);
						done_d     = (shadow_match >= limit_val);
						phase_d    = PH_TOKEN;
						cmd_push   = 1'b1;
					end
					PH_TOKEN, PH_AFTER_FLAG: begin
						if (phase_q == PH_TOKEN && shadow_q >= limit_val) begin
							// Limit reached at a token boundary: the byte is not consumed.
							cmd.kind     = CMD_END;
							cmd.consumed = consumed_q;
							cmd.fin      = 1'b1;
							done_d       = 1'b1;
							cmd_push     = 1'b1;
						end else if (phase_q == PH_TOKEN && flag_shift_q[FS_W-1]) begin
							consumed_d   = consumed_inc;
							flag_shift_d = FLAG_MARK | FS_W'(in_byte);
							phase_d      = PH_AFTER_FLAG;
						end else begin
							consumed_d   = consumed_inc;
							flag_shift_d = fs_shifted;
							if (fs_shifted[FLAG_BIT]) begin
								if (in_byte == '0) begin
									phase_d  = PH_TOKEN;
									cmd.kind = CMD_END;
									cmd.fin  = 1'b1;
									done_d   = 1'b1;
									cmd_push = 1'b1;
								end else begin
									match_high_d = in_byte;
									phase_d      = PH_MATCH2;
								end
							end else begin
								shadow_d = shadow_lit;
								cmd.kind = CMD_LIT;
								cmd.fin  = (shadow_lit >= limit_val);
								done_d   = (shadow_lit >= limit_val);
								phase_d  = PH_TOKEN;
								cmd_push = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '0;
			phase_q      <= PH_TOKEN;
			flag_shift_q <= FLAG_SHIFT_RESET;
			match_high_q <= '0;
			shadow_q     <= '0;
			consumed_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= output_limit;
			end
			phase_q      <= phase_d;
			flag_shift_q <= flag_shift_d;
			match_high_q <= match_high_d;
			shadow_q     <= shadow_d;
			consumed_q   <= consumed_d;
			done_q       <= done_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lzr_cmd_fifo.sv
// Small command queue between the parser and the copy engine.
`default_nettype none

module lzr_cmd_fifo
	import lzr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic avail,
	output cmd_t head
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	cmd_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign avail = (count_q != '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lzr_back.sv
// Back end: copy engine that writes the history ring and drives the result register.
`default_nettype none

module lzr_back
	import lzr_pkg::*;
#(
	parameter int RING_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  cmd_t               cmd_in,
	output logic               cmd_pop,
	output logic               dec_valid,
	input  logic               dec_stall,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               finished,
	output logic [COUNT_W-1:0] produced_count,
	output logic [COUNT_W-1:0] consumed_count
);

	localparam int ADDR_W = $clog2(RING_DEPTH);

	cmd_t               cur_q;
	logic               busy_q;
	logic [LEN_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  ip_q;
	logic [ADDR_W-1:0]  wp_q;
	logic               wrapped_q;
	logic [COUNT_W-1:0] produced_q;

	logic               valid_s2;
	logic               bv_s2;
	logic               use_ram_s2;
	logic               hit_s2;
	logic [BYTE_W-1:0]  data_s2;
	logic               last_s2;
	logic               fin_s2;
	logic [COUNT_W-1:0] consumed_s2;

	logic               dec_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               byte_valid_q;
	logic               run_last_q;
	logic               finished_q;
	logic [COUNT_W-1:0] produced_count_q;
	logic [COUNT_W-1:0] consumed_count_q;

	logic               out_free;
	logic               done_s2;
	logic               can_issue;
	logic               is_clear;
	logic               clear_go;
	logic               issue;
	logic               issue_last;
	logic               cmd_done;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [BYTE_W-1:0]  rd_data;
	logic               wr_en;
	logic [BYTE_W-1:0]  byte_s2;
	logic               fwd;
	logic               hit;

	assign out_free   = !dec_valid_q || !dec_stall;
	assign done_s2    = valid_s2 && out_free;
	assign can_issue  = !valid_s2 || done_s2;
	assign is_clear   = busy_q && (cur_q.kind == CMD_CLEAR);
	assign clear_go   = is_clear && !valid_s2;
	assign issue      = busy_q && !is_clear && can_issue;
	assign issue_last = (cur_q.kind != CMD_MATCH) || (rem_q == LEN_W'(1));
	assign cmd_done   = clear_go || (issue && issue_last);
	assign cmd_pop    = cmd_avail && (!busy_q || cmd_done);

	assign rd_addr = ip_q - ADDR_W'(cur_q.offset);
	assign rd_en   = issue && (cur_q.kind == CMD_MATCH);
	assign byte_s2 = use_ram_s2 ? (hit_s2 ? rd_data : '0) : data_s2;
	assign wr_en   = done_s2 && bv_s2;
	// A read of the address being written this cycle takes the new byte directly.
	assign fwd     = wr_en && (rd_addr == wp_q);
	// Entries never written since restart read as zero.
	assign hit     = wrapped_q || (rd_addr < wp_q);

	lzr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wp_q),
		.wr_data(byte_s2),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd_in;
			rem_q <= cmd_in.length;
		end else if (issue && cur_q.kind == CMD_MATCH) begin
			rem_q <= rem_q - 1'b1;
		end
		if (issue) begin
			last_s2     <= issue_last;
			fin_s2      <= cur_q.fin && issue_last;
			consumed_s2 <= cur_q.consumed;
			hit_s2      <= hit;
			case (cur_q.kind)
				CMD_LIT: begin
					bv_s2      <= 1'b1;
					use_ram_s2 <= 1'b0;
					data_s2    <= cur_q.data;
				end
				CMD_MATCH: begin
					bv_s2      <= 1'b1;
					use_ram_s2 <= !fwd;
					data_s2    <= byte_s2;
				end
				default: begin
					bv_s2      <= 1'b0;
					use_ram_s2 <= 1'b0;
					data_s2    <= '0;
				end
			endcase
		end
		if (done_s2) begin
			out_byte_q       <= byte_s2;
			byte_valid_q     <= bv_s2;
			run_last_q       <= last_s2;
			finished_q       <= fin_s2;
			produced_count_q <= bv_s2 ? produced_q + 1'b1 : produced_q;
			consumed_count_q <= consumed_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			valid_s2    <= 1'b0;
			dec_valid_q <= 1'b0;
			ip_q        <= '0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			produced_q  <= '0;
		end else begin
			if (cmd_pop) begin
				busy_q <= 1'b1;
			end else if (cmd_done) begin
				busy_q <= 1'b0;
			end

			if (issue) begin
				valid_s2 <= 1'b1;
			end else if (done_s2) begin
				valid_s2 <= 1'b0;
			end

			if (done_s2) begin
				dec_valid_q <= 1'b1;
			end else if (!dec_stall) begin
				dec_valid_q <= 1'b0;
			end

			if (clear_go) begin
				ip_q       <= '0;
				wp_q       <= '0;
				wrapped_q  <= 1'b0;
				produced_q <= '0;
			end else begin
				if (issue && cur_q.kind != CMD_END) begin
					ip_q <= ip_q + 1'b1;
				end
				if (wr_en) begin
					wp_q       <= wp_q + 1'b1;
					produced_q <= produced_q + 1'b1;
					if (wp_q == '1) begin
						wrapped_q <= 1'b1;
					end
				end
			end
		end
	end

	assign dec_valid      = dec_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_valid     = byte_valid_q;
	assign run_last       = run_last_q;
	assign finished       = finished_q;
	assign produced_count = produced_count_q;
	assign consumed_count = consumed_count_q;

endmodule

`default_nettype wire

FILE: verif/lzr_decode_checker.sv
// Checker that predicts the decompressed output and compares it with the block's output.
module lzr_decode_checker
	import lzr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] output_limit,
	input  logic               cmp_valid,
	input  logic               cmp_stall,
	input  logic               operation,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic               dec_valid,
	input  logic               dec_stall,
	input  logic [BYTE_W-1:0]  out_byte,
	input  logic               byte_valid,
	input  logic               run_last,
	input  logic               finished,
	input  logic [COUNT_W-1:0] produced_count,
	input  logic [COUNT_W-1:0] consumed_count,
	output int                 pending_count,
	output int                 fail_count
);

	localparam int                 RING_SIZE      = 4096;
	localparam logic [COUNT_W-1:0] NO_LIMIT_COUNT = 25'h1000000;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               valid;
		logic               last;
		logic               fin;
		logic [COUNT_W-1:0] produced;
		logic [COUNT_W-1:0] consumed;
	} dec_byte_t;

	dec_byte_t awaited_bytes[$];

	logic [BYTE_W-1:0]   history [RING_SIZE];
	logic [OFFSET_W-1:0] write_pos;
	logic [FS_W-1:0]     flag_bits;
	phase_t              parse_at;
	logic [BYTE_W-1:0]   match_head;
	logic [COUNT_W-1:0]  produced_total;
	logic [COUNT_W-1:0]  consumed_total;
	logic                decode_done;
	logic [LIMIT_W-1:0]  limit_copy;

	initial fail_count = 0;

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// A limit of zero stands for the full 24-bit range.
	function automatic logic [COUNT_W-1:0] stop_count();
		return (limit_copy == '0) ? NO_LIMIT_COUNT : COUNT_W'(limit_copy);
	endfunction

	task automatic clear_stream();
		foreach (history[i])
			history[i] = '0;
		write_pos      = '0;
		flag_bits      = FLAG_SHIFT_RESET;
		parse_at       = PH_TOKEN;
		match_head     = '0;
		produced_total = '0;
		consumed_total = '0;
		decode_done    = 1'b0;
	endtask

	task automatic bump_consumed();
		if (consumed_total != CONSUMED_MAX)
			consumed_total++;
	endtask

	task automatic emit_byte(input logic [BYTE_W-1:0] v);
		history[write_pos] = v;
		write_pos++;
		produced_total++;
		awaited_bytes.push_back('{v, 1'b1, 1'b0, 1'b0, produced_total, consumed_total});
	endtask

	task automatic end_decode();
		decode_done = 1'b1;
		awaited_bytes.push_back('{'0, 1'b0, 1'b1, 1'b1, produced_total, consumed_total});
	endtask

	// Tested after a whole token and at a token start, so a match may overshoot the limit.
	task automatic close_token();
		dec_byte_t tail;
		parse_at = PH_TOKEN;
		tail = awaited_bytes.pop_back();
		tail.last = 1'b1;
		if (produced_total >= stop_count()) begin
			decode_done = 1'b1;
			tail.fin    = 1'b1;
		end
		awaited_bytes.push_back(tail);
	endtask

	task automatic decode_request(input logic op, input logic [BYTE_W-1:0] b);
		logic [OFFSET_W-1:0] back;
		logic [OFFSET_W-1:0] rd_pos;
		int                  len;
		int                  i;
		if (op == OP_RESTART) begin
			clear_stream();
			return;
		end
		if (decode_done)
			return;
		if (parse_at == PH_MATCH2) begin
			bump_consumed();
			back = {match_head[7:4], b};
			len  = match_head[3:0] + LEN_BIAS;
			// One byte at a time, so an overlapping copy sees its own output.
			for (i = 0; i < len; i++) begin
				rd_pos = write_pos - back;
				emit_byte(history[rd_pos]);
			end
			close_token();
			return;
		end
		if (parse_at == PH_TOKEN) begin
			if (produced_total >= stop_count()) begin
				end_decode();
				return;
			end
			if (flag_bits[FS_W-1]) begin
				bump_consumed();
				flag_bits = FLAG_MARK | FS_W'(b);
				parse_at  = PH_AFTER_FLAG;
				return;
			end
		end
		bump_consumed();
		flag_bits = {flag_bits[FS_W-2:0], 1'b0};
		if (flag_bits[FLAG_BIT]) begin
			if (b == '0) begin
				parse_at = PH_TOKEN;
				end_decode();
				return;
			end
			match_head = b;
			parse_at   = PH_MATCH2;
			return;
		end
		emit_byte(b);
		close_token();
	endtask

	task automatic check_output();
		dec_byte_t want;
		if (awaited_bytes.size() == 0) begin
			note_mismatch("result with nothing awaited, out_byte", 32'(out_byte), 32'h0);
			return;
		end
		want = awaited_bytes.pop_front();
		if (out_byte !== want.data)
			note_mismatch("out_byte", 32'(out_byte), 32'(want.data));
		if (byte_valid !== want.valid)
			note_mismatch("byte_valid", 32'(byte_valid), 32'(want.valid));
		if (run_last !== want.last)
			note_mismatch("run_last", 32'(run_last), 32'(want.last));
		if (finished !== want.fin)
			note_mismatch("finished", 32'(finished), 32'(want.fin));
		if (produced_count !== want.produced)
			note_mismatch("produced_count", 32'(produced_count), 32'(want.produced));
		if (consumed_count !== want.consumed)
			note_mismatch("consumed_count", 32'(consumed_count), 32'(want.consumed));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stream();
			limit_copy = '0;
			awaited_bytes.delete();
			pending_count <= 0;
		end else begin
			if (cfg_wr_en)
				limit_copy = output_limit;
			if (cmp_valid && !cmp_stall)
				decode_request(operation, in_byte);
			if (dec_valid && !dec_stall)
				check_output();
			pending_count <= awaited_bytes.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the decompressor testbench: clock, reset, stimulus, output stalls and the verdict.
module testbench;
	import lzr_pkg::*;

	// Target count of random requests; the noise bytes sent right after an end marker
	// are ignored by the block and are not counted.
	localparam int                RANDOM_ITEMS  = 350;
	// Pause after the last awaited result, so that flag bytes and restarts that give
	// no result have left the command queue before the register is touched.
	localparam int                SETTLE_CYCLES = 32;
	// One long stretch of output stall, to fill the queue and push back on the input.
	localparam int                LONG_HOLD     = 300;
	localparam int                RUN_LIMIT     = 6_000_000;
	localparam logic [BYTE_W-1:0] END_MARKER    = 8'h00;

	localparam logic [BYTE_W-1:0] EDGE_BYTES [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic [LIMIT_W-1:0] output_limit = '0;
	logic               cmp_valid    = 1'b0;
	logic               cmp_stall;
	logic               operation    = OP_DATA;
	logic [BYTE_W-1:0]  in_byte      = '0;
	logic               dec_valid;
	logic               dec_stall    = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               byte_valid;
	logic               run_last;
	logic               finished;
	logic [COUNT_W-1:0] produced_count;
	logic [COUNT_W-1:0] consumed_count;
	int                 pending_count;
	int                 fail_count;

	int live_items  = 0;
	bit tx_gapless  = 1'b0;
	bit rx_hold_req = 1'b0;

	lzss_ring_decompressor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.output_limit  (output_limit),
		.cmp_valid     (cmp_valid),
		.cmp_stall     (cmp_stall),
		.operation     (operation),
		.in_byte       (in_byte),
		.dec_valid     (dec_valid),
		.dec_stall     (dec_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.finished      (finished),
		.produced_count(produced_count),
		.consumed_count(consumed_count)
	);

	lzr_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.output_limit  (output_limit),
		.cmp_valid     (cmp_valid),
		.cmp_stall     (cmp_stall),
		.operation     (operation),
		.in_byte       (in_byte),
		.dec_valid     (dec_valid),
		.dec_stall     (dec_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.finished      (finished),
		.produced_count(produced_count),
		.consumed_count(consumed_count),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	always #6 clk = ~clk;

	// Offers one compressed request after a random gap and holds it until the block
	// takes it. Valid only drops when a gap follows, so a back-to-back request never
	// sees valid lowered and raised in the same time step.
	task automatic send_request(input logic op, input logic [BYTE_W-1:0] b, input bit counted);
		int gap;
		gap = tx_gapless ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmp_valid <= 1'b1;
		operation <= op;
		in_byte   <= b;
		do @(posedge clk); while (cmp_stall);
		if (counted)
			live_items++;
	endtask

	// Stops offering requests and waits until every awaited result has come out,
	// then lets the block run dry.
	task automatic settle_block();
		cmp_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The limit register is only ever written while the block is idle.
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		settle_block();
		cfg_wr_en    <= 1'b1;
		output_limit <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// One well-formed stream with random content: a restart, then up to four flag
	// groups of literals and matches. Matches mostly point a short way back so they
	// copy real history; some reach anywhere in the window. Now and then the stream
	// ends on a zero marker followed by bytes the block must ignore, or breaks off
	// in the middle of a match.
	task automatic send_stream();
		int                  groups;
		int                  g;
		int                  k;
		int                  noise;
		logic [BYTE_W-1:0]   flags;
		logic [OFFSET_W-1:0] back;
		logic [BYTE_W-1:0]   head;
		tx_gapless = ($urandom_range(0, 3) == 0);
		send_request(OP_RESTART, BYTE_W'($urandom), 1'b1);
		groups = $urandom_range(1, 4);
		for (g = 0; g < groups; g++) begin
			case ($urandom_range(0, 5))
				0: flags = 8'h00;
				1: flags = 8'hFF;
				default: flags = BYTE_W'($urandom);
			endcase
			send_request(OP_DATA, flags, 1'b1);
			for (k = 7; k >= 0; k--) begin
				if (!flags[k]) begin
					send_request(OP_DATA, BYTE_W'($urandom), 1'b1);
				end else if ($urandom_range(0, 15) == 0) begin
					send_request(OP_DATA, END_MARKER, 1'b1);
					noise = $urandom_range(0, 2);
					repeat (noise) send_request(OP_DATA, BYTE_W'($urandom), 1'b0);
					return;
				end else begin
					if ($urandom_range(0, 3) != 0)
						back = OFFSET_W'($urandom_range(1, 24));
					else
						back = OFFSET_W'($urandom);
					head = {back[11:8], 4'($urandom)};
					// A zero first byte would be the end marker, not a match.
					if (head == END_MARKER)
						head = 8'h01;
					send_request(OP_DATA, head, 1'b1);
					if ($urandom_range(0, 40) == 0)
						return;
					send_request(OP_DATA, back[7:0], 1'b1);
				end
			end
		end
	endtask

	// Output side: may stall before each result, with stretches of
	// no stall at all, and once holds off for a long time when the stimulus asks.
	initial begin : receiver
		int wait_cycles;
		int taken;
		bit rx_gapless;
		bit held;
		taken      = 0;
		rx_gapless = 1'b0;
		held       = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req && !held) begin
				wait_cycles = LONG_HOLD;
				held        = 1'b1;
			end else if (rx_gapless) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 7);
			end
			if (wait_cycles > 0) begin
				dec_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			dec_stall <= 1'b0;
			do @(posedge clk); while (!dec_valid);
			taken++;
			if (taken % 40 == 0)
				rx_gapless = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : stimulus
		int                 phase_no;
		int                 budget;
		int                 phase_start;
		logic [LIMIT_W-1:0] lim;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, unlimited output first.
		write_limit('0);
		send_request(OP_RESTART, 8'h00, 1'b0);
		// Six literals at the extremes of the byte, then two matches: the longest copy
		// at distance one, which overlaps its own output, and the farthest distance,
		// which reads never-written zeros.
		send_request(OP_DATA, 8'h03, 1'b0);
		foreach (EDGE_BYTES[i])
			send_request(OP_DATA, EDGE_BYTES[i], 1'b0);
		send_request(OP_DATA, 8'h0F, 1'b0);
		send_request(OP_DATA, 8'h01, 1'b0);
		send_request(OP_DATA, 8'hF0, 1'b0);
		send_request(OP_DATA, 8'hFF, 1'b0);
		// A match at distance zero, then the end marker, then a byte after the end.
		send_request(OP_DATA, 8'hC0, 1'b0);
		send_request(OP_DATA, 8'h01, 1'b0);
		send_request(OP_DATA, 8'h00, 1'b0);
		send_request(OP_DATA, END_MARKER, 1'b0);
		send_request(OP_DATA, 8'h42, 1'b0);
		// Limit lowered to the produced count: the next token ends decoding at once.
		send_request(OP_RESTART, 8'hFF, 1'b0);
		send_request(OP_DATA, 8'h00, 1'b0);
		send_request(OP_DATA, 8'h11, 1'b0);
		send_request(OP_DATA, 8'h22, 1'b0);
		write_limit(24'd2);
		send_request(OP_DATA, 8'h33, 1'b0);

		// Random part in phases, each with its own limit: all ones, zero (meaning no
		// limit), tiny limits that end streams early, moderate ones that are hit in the
		// middle of longer streams, and random ones. Every phase starts from an idle block.
		phase_no = 0;
		while (live_items < RANDOM_ITEMS) begin
			case (phase_no % 6)
				0: lim = 24'hFFFFFF;
				1: lim = LIMIT_W'($urandom_range(1, 12));
				2: lim = '0;
				3: lim = LIMIT_W'($urandom_range(13, 200));
				4: lim = LIMIT_W'($urandom);
				default: lim = 24'd1;
			endcase
			budget = (lim != '0 && lim < 64) ? 25 : 70;
			write_limit(lim);
			phase_start = live_items;
			while (live_items - phase_start < budget && live_items < RANDOM_ITEMS) begin
				if (live_items > 120)
					rx_hold_req = 1'b1;
				send_stream();
				if ($urandom_range(0, 4) == 0)
					send_request(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_DATA,
						BYTE_W'($urandom), 1'b1);
			end
			phase_no++;
		end

		settle_block();
		if (fail_count == 0 && pending_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin : watchdog
		#RUN_LIMIT;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/lzr_pkg.sv
rtl/lzr_ram.sv
rtl/lzr_front.sv
rtl/lzr_cmd_fifo.sv
rtl/lzr_back.sv
rtl/lzss_ring_decompressor.sv
verif/lzr_decode_checker.sv
verif/testbench.sv
